// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the transmitter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/irpdt_pkg.sv =====
// Package for the IR pulse-distance transmitter: widths, codes and shared types.
// No dependencies.
package irpdt_pkg;

    localparam int FRAME_W    = 64;
    localparam int LEN_W      = 7;
    localparam int UNIT_W     = 8;
    localparam int CNT_W      = 11;
    localparam int STATE_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SLOTS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ENABLE = 1'd1;
    localparam logic [UNIT_W-1:0]    UNIT_SLOTS_RESET  = 8'd11;
    localparam logic                 PARITY_RESET      = 1'b1;

    // Input word function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // Slot machine states
    localparam logic [STATE_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [STATE_W-1:0] ST_HDR_MARK   = 4'd1;
    localparam logic [STATE_W-1:0] ST_HDR_SPACE  = 4'd2;
    localparam logic [STATE_W-1:0] ST_ZERO_MARK  = 4'd3;
    localparam logic [STATE_W-1:0] ST_ZERO_SPACE = 4'd4;
    localparam logic [STATE_W-1:0] ST_ONE_MARK   = 4'd5;
    localparam logic [STATE_W-1:0] ST_ONE_SPACE  = 4'd6;
    localparam logic [STATE_W-1:0] ST_TRL_MARK   = 4'd7;
    localparam logic [STATE_W-1:0] ST_TRL_SPACE  = 4'd8;

    typedef struct packed {
        logic valid;
        logic func;
    } irpdt_step_t;

    typedef struct packed {
        logic ir_level;
        logic busy;
    } irpdt_result_t;

endpackage

// ===== hdl/irpdt_if.sv =====
// Handshake channels of the IR pulse-distance transmitter: item words in, result words out.
// Depends on irpdt_pkg.
interface irpdt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [irpdt_pkg::FRAME_W-1:0] frame;
    logic [irpdt_pkg::LEN_W-1:0]   frame_length;

    modport source (output valid, output func, output frame, output frame_length,
                    input ready);
    modport sink   (input valid, input func, input frame, input frame_length,
                    output ready);
endinterface

interface irpdt_out_if;
    logic valid;
    logic ready;
    logic ir_level;
    logic busy_res;

    modport source (output valid, output ir_level, output busy_res, input ready);
    modport sink   (input valid, input ir_level, input busy_res, output ready);
endinterface

// ===== hdl/irpdt_frame_prep.sv =====
// Frame prep: clip length, mask unused bits, apply odd parity to bit 0 if enabled.
// Depends on irpdt_pkg.
module irpdt_frame_prep #(
    parameter int MAX_FRAME_BITS = 64
) (
    input  logic [MAX_FRAME_BITS-1:0]   frame,
    input  logic [irpdt_pkg::LEN_W-1:0] frame_length,
    input  logic                        parity_enable,
    output logic [MAX_FRAME_BITS-1:0]   frame_out,
    output logic [irpdt_pkg::LEN_W-1:0] length_out
);

    localparam logic [irpdt_pkg::LEN_W-1:0] MAX_LEN = irpdt_pkg::LEN_W'(MAX_FRAME_BITS);

    logic [MAX_FRAME_BITS-1:0] keep;
    logic [MAX_FRAME_BITS-1:0] masked;
    logic                      upper_parity;

    assign length_out = (frame_length > MAX_LEN) ? MAX_LEN : frame_length;

    always_comb
    begin
        for (int i = 0; i < MAX_FRAME_BITS; i++)
        begin
            keep[i] = (length_out > irpdt_pkg::LEN_W'(i));
        end
    end

    assign masked       = frame & keep;
    assign upper_parity = ^masked[MAX_FRAME_BITS-1:1];

    // With parity enabled, set bit 0 when the upper bits hold an even count of ones
    assign frame_out = {masked[MAX_FRAME_BITS-1:1],
                        parity_enable ? ~upper_parity : masked[0]};

endmodule

// ===== hdl/irpdt_sequencer.sv =====
// Tick phase counter, slot machine and frame store of the transmitter.
// Depends on irpdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irpdt_sequencer #(
    parameter int MAX_FRAME_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  irpdt_pkg::irpdt_step_t         step,
    input  logic [MAX_FRAME_BITS-1:0]      frame,
    input  logic [irpdt_pkg::LEN_W-1:0]    frame_length,
    input  logic [irpdt_pkg::UNIT_W-1:0]   unit_slots,
    output irpdt_pkg::irpdt_result_t       result
);

    localparam int IDX_W = $clog2(MAX_FRAME_BITS);
    localparam logic [irpdt_pkg::LEN_W-1:0] MAX_LEN = irpdt_pkg::LEN_W'(MAX_FRAME_BITS);

    localparam logic [1:0] PH_REST = 2'd0;
    localparam logic [1:0] PH_MARK = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic [irpdt_pkg::STATE_W-1:0] state_reg, state_next;
    logic [irpdt_pkg::CNT_W-1:0]   slot_count_reg, slot_count_next;
    logic [irpdt_pkg::LEN_W-1:0]   bit_index_reg, bit_index_next;
    logic [irpdt_pkg::LEN_W-1:0]   frame_bits_reg, frame_bits_next;
    logic [1:0]                    phase_reg, phase_next;
    logic                          marked_reg, marked_next;
    logic                          ticking_reg, ticking_next;
    logic [MAX_FRAME_BITS-1:0]     frame_store_reg;

    logic [irpdt_pkg::CNT_W-1:0]   dur_1, dur_3, dur_5, cnt_inc;
    logic [irpdt_pkg::LEN_W-1:0]   bit_inc;
    logic                          next_bit_one;
    logic [irpdt_pkg::STATE_W-1:0] next_bit_state;
    logic [irpdt_pkg::STATE_W-1:0] first_bit_state;
    logic                          level;

    assign dur_1   = irpdt_pkg::CNT_W'(unit_slots);
    assign dur_3   = (dur_1 << 1) + dur_1;
    assign dur_5   = (dur_1 << 2) + dur_1;
    assign cnt_inc = slot_count_reg + 1'b1;
    assign bit_inc = bit_index_reg + 1'b1;

    assign next_bit_one    = (bit_inc < MAX_LEN) ? frame_store_reg[bit_inc[IDX_W-1:0]] : 1'b0;
    assign next_bit_state  = next_bit_one ? irpdt_pkg::ST_ONE_MARK : irpdt_pkg::ST_ZERO_MARK;
    assign first_bit_state = frame_store_reg[0] ? irpdt_pkg::ST_ONE_MARK
                                                : irpdt_pkg::ST_ZERO_MARK;

    always_comb
    begin
        state_next      = state_reg;
        slot_count_next = slot_count_reg;
        bit_index_next  = bit_index_reg;
        frame_bits_next = frame_bits_reg;
        phase_next      = phase_reg;
        marked_next     = marked_reg;
        ticking_next    = ticking_reg;
        level           = 1'b0;

        if (step.valid)
        begin
            if (step.func == irpdt_pkg::FUNC_START)
            begin
                // Replace the frame; a running frame keeps its position
                frame_bits_next = frame_length;
                ticking_next    = 1'b1;
                if (state_reg == irpdt_pkg::ST_IDLE)
                begin
                    state_next = irpdt_pkg::ST_HDR_MARK;
                end
                level = (phase_reg == PH_MARK) && marked_reg;
            end
            else if (ticking_reg)
            begin
                case (phase_reg)
                    PH_REST:
                    begin
                        phase_next = PH_MARK;
                        level      = marked_reg;
                    end
                    PH_MARK:
                    begin
                        phase_next = PH_LOW;
                    end
                    default:
                    begin
                        phase_next      = PH_REST;
                        slot_count_next = cnt_inc;
                        case (state_reg)
                            irpdt_pkg::ST_IDLE:
                            begin
                                marked_next     = 1'b0;
                                slot_count_next = '0;
                                ticking_next    = 1'b0;
                            end
                            irpdt_pkg::ST_HDR_MARK:
                            begin
                                marked_next = 1'b1;
                                if (cnt_inc >= dur_5)
                                begin
                                    state_next      = irpdt_pkg::ST_HDR_SPACE;
                                    slot_count_next = '0;
                                end
                            end
                            irpdt_pkg::ST_HDR_SPACE:
                            begin
                                marked_next = 1'b0;
                                if (cnt_inc >= dur_5)
                                begin
                                    slot_count_next = '0;
                                    bit_index_next  = '0;
                                    state_next      = first_bit_state;
                                end
                            end
                            irpdt_pkg::ST_ZERO_MARK,
                            irpdt_pkg::ST_ONE_MARK:
                            begin
                                marked_next = 1'b1;
                                if (cnt_inc >= dur_1)
                                begin
                                    slot_count_next = '0;
                                    state_next = (state_reg == irpdt_pkg::ST_ZERO_MARK)
                                                 ? irpdt_pkg::ST_ZERO_SPACE
                                                 : irpdt_pkg::ST_ONE_SPACE;
                                end
                            end
                            irpdt_pkg::ST_ZERO_SPACE,
                            irpdt_pkg::ST_ONE_SPACE:
                            begin
                                marked_next = 1'b0;
                                if ((state_reg == irpdt_pkg::ST_ZERO_SPACE && cnt_inc >= dur_1)
                                    || (state_reg == irpdt_pkg::ST_ONE_SPACE
                                        && cnt_inc >= dur_3))
                                begin
                                    // End of bit: advance or drop into the trailer
                                    slot_count_next = '0;
                                    bit_index_next  = bit_inc;
                                    state_next = (bit_inc >= frame_bits_reg)
                                                 ? irpdt_pkg::ST_TRL_MARK : next_bit_state;
                                end
                            end
                            irpdt_pkg::ST_TRL_MARK:
                            begin
                                if (cnt_inc >= dur_3)
                                begin
                                    state_next      = irpdt_pkg::ST_TRL_SPACE;
                                    slot_count_next = '0;
                                end
                                else
                                begin
                                    marked_next = 1'b1;
                                end
                            end
                            irpdt_pkg::ST_TRL_SPACE:
                            begin
                                marked_next = 1'b0;
                                if (cnt_inc >= dur_3)
                                begin
                                    state_next      = irpdt_pkg::ST_IDLE;
                                    slot_count_next = '0;
                                end
                            end
                            default:
                            begin
                                slot_count_next = cnt_inc;
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    assign result.ir_level = level;
    assign result.busy     = (state_next != irpdt_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= irpdt_pkg::ST_IDLE;
            slot_count_reg <= '0;
            bit_index_reg  <= '0;
            frame_bits_reg <= '0;
            phase_reg      <= PH_REST;
            marked_reg     <= 1'b0;
            ticking_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            bit_index_reg  <= bit_index_next;
            frame_bits_reg <= frame_bits_next;
            phase_reg      <= phase_next;
            marked_reg     <= marked_next;
            ticking_reg    <= ticking_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid && step.func == irpdt_pkg::FUNC_START)
        begin
            frame_store_reg <= frame;
        end
    end

    `ASSERT_IMPLIES(a_level_needs_mark, step.valid && result.ir_level, marked_reg, "carrier driven for an unmarked slot")
    `ASSERT_IMPLIES(a_stopped_is_idle, !ticking_reg, state_reg == irpdt_pkg::ST_IDLE, "tick machine stopped while a frame is pending")
    `ASSERT_NEXT(a_idle_tick_holds, step.valid && step.func == irpdt_pkg::FUNC_TICK && !ticking_reg, $stable(state_reg) && $stable(phase_reg), "tick changed state while stopped")

endmodule

// ===== hdl/ir_pulse_distance_transmitter.sv =====
// Top level of the IR pulse-distance transmitter: input register, frame prep, sequencer,
// result register and configuration registers.
// Depends on irpdt_pkg, irpdt_if, irpdt_frame_prep, irpdt_sequencer, assert_macros.svh.
`include "assert_macros.svh"

// An accepted word waits in the input register until the result stage takes it.
// Throughput: one item word per cycle unless the output stalls; the two registers
// form a two-deep pipeline, and the slot machine update is one pass of logic.
// Reset: control state, unit_slots (11) and parity_enable (1) reset at once; the
// frame store is loaded by the first start and holds no reset value.
module ir_pulse_distance_transmitter #(
    parameter int MAX_FRAME_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpdt_pkg::CFG_DATA_W-1:0]   cfg_data,
    irpdt_in_if.sink                           item,
    irpdt_out_if.source                        result
);

    // Configuration registers
    logic [irpdt_pkg::UNIT_W-1:0] unit_slots_reg;
    logic                         parity_enable_reg;

    // Input stage: hold the accepted word until it can pass into the result stage
    logic                          in_valid_reg, in_valid_next;
    logic                          in_func_reg;
    logic [MAX_FRAME_BITS-1:0]     in_frame_reg;
    logic [irpdt_pkg::LEN_W-1:0]   in_length_reg;

    // Result stage
    logic                          out_valid_reg, out_valid_next;
    logic                          out_level_reg;
    logic                          out_busy_reg;

    logic                          advance;
    logic                          accept;
    logic [MAX_FRAME_BITS-1:0]     prep_frame;
    logic [irpdt_pkg::LEN_W-1:0]   prep_length;
    irpdt_pkg::irpdt_step_t        step;
    irpdt_pkg::irpdt_result_t      step_result;

    // The input word moves on whenever the result register is free or being drained
    assign advance     = !out_valid_reg || result.ready;
    assign item.ready  = !in_valid_reg || advance;
    assign accept      = item.valid && item.ready;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = (in_valid_reg && advance) || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_slots_reg    <= irpdt_pkg::UNIT_SLOTS_RESET;
            parity_enable_reg <= irpdt_pkg::PARITY_RESET;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == irpdt_pkg::CFG_UNIT_SLOTS)
            begin
                unit_slots_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == irpdt_pkg::CFG_PARITY_ENABLE)
            begin
                parity_enable_reg <= cfg_data[0];
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load the input word on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_func_reg   <= item.func;
            in_frame_reg  <= item.frame[MAX_FRAME_BITS-1:0];
            in_length_reg <= item.frame_length;
        end
    end

    irpdt_frame_prep #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_frame_prep (
        .frame         (in_frame_reg),
        .frame_length  (in_length_reg),
        .parity_enable (parity_enable_reg),
        .frame_out     (prep_frame),
        .length_out    (prep_length)
    );

    // The sequencer commits state only when the word passes into the result stage
    assign step.valid = in_valid_reg && advance;
    assign step.func  = in_func_reg;

    irpdt_sequencer #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .frame        (prep_frame),
        .frame_length (prep_length),
        .unit_slots   (unit_slots_reg),
        .result       (step_result)
    );

    // Result payload: capture the sequencer output as the word moves on
    always_ff @(posedge clk)
    begin
        if (step.valid)
        begin
            out_level_reg <= step_result.ir_level;
            out_busy_reg  <= step_result.busy;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.ir_level = out_level_reg;
    assign result.busy_res = out_busy_reg;

    `ASSERT_IMPLIES(a_ready_when_drained, !out_valid_reg, item.ready, "input stalled with an empty result register")
    `ASSERT_NEXT(a_step_fills_result, step.valid, out_valid_reg, "stepped word did not reach the result register")

endmodule

// ===== tb/tb_ir_pulse_distance_transmitter.sv =====
// Self-checking testbench for the IR pulse-distance transmitter: a directed plan, then random
// frames under three idle patterns, every result word checked against an in-bench predictor.
// Depends on irpdt_pkg, irpdt_if and the ir_pulse_distance_transmitter RTL.
module tb_ir_pulse_distance_transmitter;
    timeunit 1ns;
    timeprecision 1ps;

    import irpdt_pkg::*;

    // Quiet cycles allowed before the run is declared hung. The longest honest gap is the
    // receiver hold-off plus a sender gap and a register write, well under this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the receiver hold-off that fills the two-deep pipeline.
    localparam int HOLD_CYCLES    = 120;
    // Live words per random phase; with the directed plan the run sends about 1600.
    localparam int PHASE_WORDS    = 90;
    localparam int RANDOM_PHASES  = 6;
    localparam int MAX_BITS       = 64;
    // Plan tail value: keep ticking until the tick machine stops.
    localparam int TO_IDLE        = -1;

    localparam irpdt_result_t PIN_QUIET = '{ir_level: 1'b0, busy: 1'b0};
    localparam irpdt_result_t PIN_BUSY  = '{ir_level: 1'b0, busy: 1'b1};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    irpdt_in_if  item_ch ();
    irpdt_out_if res_ch ();

    ir_pulse_distance_transmitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the slot machine and registers
    // ------------------------------------------------------------------
    logic [STATE_W-1:0] tx_state;
    logic [CNT_W-1:0]   tx_slot;
    logic [LEN_W-1:0]   tx_bit;
    logic [FRAME_W-1:0] tx_frame;
    logic [LEN_W-1:0]   tx_nbits;
    logic [1:0]         tx_phase;
    logic               tx_mark;
    logic               tx_run;
    logic [UNIT_W-1:0]  unit_now;
    logic               parity_now;

    irpdt_result_t pin_expected [$];

    int err_count     = 0;
    int live_words    = 0;
    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    bit hold_request  = 1'b0;
    int quiet_cycles  = 0;

    // Mark state that sends frame bit idx.
    function automatic logic [STATE_W-1:0] mark_state_of(input logic [LEN_W-1:0] idx);
        if (idx < MAX_BITS && tx_frame[idx[5:0]])
            return ST_ONE_MARK;
        return ST_ZERO_MARK;
    endfunction

    // Step past a finished bit: next bit, or the trailer once the length is used up.
    function automatic void close_bit();
        tx_slot = '0;
        tx_bit  = tx_bit + 1'b1;
        if (tx_bit >= tx_nbits)
            tx_state = ST_TRL_MARK;
        else
            tx_state = mark_state_of(tx_bit);
    endfunction

    // One slot of the slot machine, run at every third tick.
    function automatic void next_slot();
        int u1;
        int u3;
        int u5;
        int cnt;
        u1 = int'(unit_now);
        u3 = 3 * u1;
        u5 = 5 * u1;
        tx_slot = tx_slot + 1'b1;
        cnt = int'(tx_slot);
        case (tx_state)
            ST_IDLE:
            begin
                // One slot after going idle the tick machine stops.
                tx_mark = 1'b0;
                tx_slot = '0;
                tx_run  = 1'b0;
            end
            ST_HDR_MARK:
            begin
                tx_mark = 1'b1;
                if (cnt >= u5)
                begin
                    tx_state = ST_HDR_SPACE;
                    tx_slot  = '0;
                end
            end
            ST_HDR_SPACE:
            begin
                tx_mark = 1'b0;
                if (cnt >= u5)
                begin
                    tx_slot  = '0;
                    tx_bit   = '0;
                    tx_state = mark_state_of('0);
                end
            end
            ST_ZERO_MARK, ST_ONE_MARK:
            begin
                tx_mark = 1'b1;
                if (cnt >= u1)
                begin
                    tx_slot  = '0;
                    tx_state = (tx_state == ST_ZERO_MARK) ? ST_ZERO_SPACE : ST_ONE_SPACE;
                end
            end
            ST_ZERO_SPACE:
            begin
                tx_mark = 1'b0;
                if (cnt >= u1)
                    close_bit();
            end
            ST_ONE_SPACE:
            begin
                tx_mark = 1'b0;
                if (cnt >= u3)
                    close_bit();
            end
            ST_TRL_MARK:
            begin
                // The last trailer slot already leaves the mark as it was.
                if (cnt >= u3)
                begin
                    tx_state = ST_TRL_SPACE;
                    tx_slot  = '0;
                end
                else
                    tx_mark = 1'b1;
            end
            ST_TRL_SPACE:
            begin
                tx_mark = 1'b0;
                if (cnt >= u3)
                begin
                    tx_state = ST_IDLE;
                    tx_slot  = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // Work out the pin level and busy flag caused by one accepted item word.
    function automatic irpdt_result_t predict_pin(input logic func,
                                                  input logic [FRAME_W-1:0] bits,
                                                  input logic [LEN_W-1:0] len);
        irpdt_result_t pin;
        logic [LEN_W-1:0]   n;
        logic [FRAME_W-1:0] f;
        pin.ir_level = 1'b0;
        if (func == FUNC_START)
        begin
            // Saturate the length, clear bits above it, then, if parity is on, force odd parity on bit 0.
            // A zero length still sends one bit.
            n = (len > MAX_BITS) ? LEN_W'(MAX_BITS) : len;
            f = (n >= MAX_BITS) ? bits : (bits & ((64'd1 << n) - 64'd1));
            if (parity_now)
                f[0] = (($countones(f[FRAME_W-1:1]) % 2) == 0);
            tx_frame = f;
            tx_nbits = n;
            // A start while busy swaps the frame but keeps the machine where it is.
            if (tx_state == ST_IDLE)
                tx_state = ST_HDR_MARK;
            tx_run = 1'b1;
            // The pin stays as the last tick left it.
            pin.ir_level = (tx_phase == 2'd1) && tx_mark;
        end
        else if (tx_run)
        begin
            case (tx_phase)
                2'd0:
                begin
                    tx_phase     = 2'd1;
                    pin.ir_level = tx_mark;
                end
                2'd1:
                    tx_phase = 2'd2;
                default:
                begin
                    tx_phase = 2'd0;
                    next_slot();
                end
            endcase
        end
        pin.busy = (tx_state != ST_IDLE);
        return pin;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic want, input logic got);
        $display("%0t mismatch: %s expected %b got %b", $realtime, what, want, got);
        err_count++;
    endtask

    task automatic check_pin(input irpdt_result_t got);
        irpdt_result_t want;
        if (pin_expected.size() == 0)
            report_mismatch("result word with nothing pending, ir_level", 1'bx, got.ir_level);
        else
        begin
            want = pin_expected.pop_front();
            if (got.ir_level !== want.ir_level)
                report_mismatch("ir_level", want.ir_level, got.ir_level);
            if (got.busy !== want.busy)
                report_mismatch("busy_res", want.busy, got.busy);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item word after a random gap, wait for the handshake, then predict.
    // Valid stays high on return so words can go back to back.
    task automatic send_word(input logic func, input logic [FRAME_W-1:0] bits,
                             input logic [LEN_W-1:0] len, input bit typed = 1'b0,
                             input irpdt_result_t want = PIN_QUIET);
        irpdt_result_t pin;
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.func         <= func;
        item_ch.frame        <= bits;
        item_ch.frame_length <= len;
        do
            @(posedge clk);
        while (!item_ch.ready);
        // Ticks to a stopped tick machine do nothing and are not counted.
        if (func == FUNC_START || tx_run)
            live_words++;
        pin = predict_pin(func, bits, len);
        // Typed rows carry their own expectation; the predictor still advances.
        pin_expected.push_back(typed ? want : pin);
    endtask

    // Tick words carry junk in the unused fields.
    task automatic send_tick();
        send_word(FUNC_TICK, {$urandom, $urandom}, LEN_W'($urandom));
    endtask

    // Write one register once the block has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        item_ch.valid <= 1'b0;
        while (pin_expected.size() != 0)
            @(posedge clk);
        // Let the pipeline settle before touching a register.
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_UNIT_SLOTS)
            unit_now = value[UNIT_W-1:0];
        else
            parity_now = value[0];
    endtask

    // Write both registers; the parity word carries junk above bit 0.
    task automatic apply_setting(input logic [UNIT_W-1:0] unit, input logic par);
        logic [CFG_DATA_W-1:0] word;
        word    = CFG_DATA_W'($urandom);
        word[0] = par;
        write_reg(CFG_UNIT_SLOTS, CFG_DATA_W'(unit));
        write_reg(CFG_PARITY_ENABLE, word);
    endtask

    // Frame lengths lean short so many frames fit; a few are long, zero or saturating.
    function automatic logic [LEN_W-1:0] rand_len();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return LEN_W'($urandom_range(1, 4));
        if (p < 85)
            return LEN_W'($urandom_range(5, 16));
        if (p < 93)
            return LEN_W'($urandom_range(17, MAX_BITS));
        return LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        int p;
        p = $urandom_range(99);
        if (p < 8)
            return '1;
        if (p < 14)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // One random episode: mostly a whole frame with an odd replacement start,
    // sometimes a frame cut short, sometimes a few loose ticks.
    task automatic random_frame_run();
        int pick;
        int cut;
        pick = $urandom_range(99);
        if (pick < 8)
            repeat ($urandom_range(1, 5)) send_tick();
        else
        begin
            send_word(FUNC_START, rand_frame(), rand_len());
            cut = (pick < 20) ? $urandom_range(5, 120) : 32'h3fff_ffff;
            while (tx_run && cut > 0)
            begin
                if (tx_state != ST_IDLE && $urandom_range(199) == 0)
                    send_word(FUNC_START, rand_frame(), rand_len());
                else
                    send_tick();
                cut--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed plan
    // ------------------------------------------------------------------
    typedef struct {
        logic [UNIT_W-1:0]  unit;
        logic               par;
        logic               func;
        logic [FRAME_W-1:0] bits;
        logic [LEN_W-1:0]   len;
        bit                 typed;
        irpdt_result_t      want;
        int                 tail;
    } plan_row_t;

    localparam int PLAN_ROWS = 17;

    plan_row_t plan [PLAN_ROWS] = '{
        // tick straight after reset: nothing running
        '{8'd11,  1'b1, FUNC_TICK,  64'd0,                 7'd0,   1'b1, PIN_QUIET, 0},
        // reset setting, zero frame of one bit, run into the header
        '{8'd11,  1'b1, FUNC_START, 64'd0,                 7'd1,   1'b1, PIN_BUSY, 30},
        // replace it with a saturating full-length all-ones frame at unit zero
        '{8'd0,   1'b1, FUNC_START, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, PIN_QUIET, TO_IDLE},
        // saturating length with the top bit set, then cut short by a one-bit frame
        '{8'd0,   1'b1, FUNC_START, 64'h8000_0000_0000_0001, 7'd65, 1'b1, PIN_BUSY, 45},
        '{8'd0,   1'b1, FUNC_START, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1,  1'b0, PIN_QUIET, TO_IDLE},
        // zero length still sends bit 0, with and without parity
        '{8'd1,   1'b0, FUNC_START, 64'hA5A5_5A5A_0F0F_F0F0, 7'd0,  1'b1, PIN_BUSY, TO_IDLE},
        '{8'd1,   1'b1, FUNC_START, 64'h6,                 7'd0,   1'b1, PIN_BUSY, TO_IDLE},
        // start into the data part, then replace with a shorter frame
        '{8'd1,   1'b1, FUNC_START, 64'h3,                 7'd8,   1'b1, PIN_BUSY, 45},
        '{8'd1,   1'b1, FUNC_START, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1,  1'b0, PIN_QUIET, TO_IDLE},
        // one-bit frame, then replace with a longer one inside its last bit
        '{8'd1,   1'b1, FUNC_START, 64'h1,                 7'd1,   1'b1, PIN_BUSY, 40},
        '{8'd1,   1'b1, FUNC_START, 64'hF0F0,              7'd16,  1'b0, PIN_QUIET, TO_IDLE},
        // unit zero: one slot per state
        '{8'd0,   1'b1, FUNC_START, 64'h5,                 7'd3,   1'b1, PIN_BUSY, TO_IDLE},
        // largest unit counts partway into the header, then unit zero finishes the frame
        '{8'd255, 1'b0, FUNC_START, 64'h2,                 7'd2,   1'b1, PIN_BUSY, 30},
        '{8'd0,   1'b0, FUNC_START, 64'h2,                 7'd2,   1'b0, PIN_QUIET, TO_IDLE},
        '{8'd0,   1'b0, FUNC_TICK,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1, PIN_QUIET, 0},
        // start while the pin is on: the start word reports the lit pin
        '{8'd1,   1'b1, FUNC_START, 64'hC3,                7'd8,   1'b1, PIN_BUSY, 4},
        '{8'd1,   1'b1, FUNC_START, 64'h3C,                7'd8,   1'b0, PIN_QUIET, TO_IDLE}
    };

    // ------------------------------------------------------------------
    // Receiver: random ready, a long hold-off on request, and the check
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        irpdt_result_t seen;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                seen.ir_level = res_ch.ir_level;
                seen.busy     = res_ch.busy_res;
                check_pin(seen);
            end
            // Hold ready low long enough for the input side to back up.
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int stop_at;
        logic [UNIT_W-1:0] unit;
        logic par;

        // Drive every input to a known value and hold reset.
        item_ch.valid        <= 1'b0;
        item_ch.func         <= FUNC_TICK;
        item_ch.frame        <= '0;
        item_ch.frame_length <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        rst_n                <= 1'b0;

        tx_state   = ST_IDLE;
        tx_slot    = '0;
        tx_bit     = '0;
        tx_frame   = '0;
        tx_nbits   = '0;
        tx_phase   = '0;
        tx_mark    = 1'b0;
        tx_run     = 1'b0;
        unit_now   = UNIT_SLOTS_RESET;
        parity_now = PARITY_RESET;

        // First idle pattern: sender sparse, receiver sparser.
        send_gap_pct = 27;
        recv_gap_pct = 47;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan; rewrite registers only when a row asks for new ones.
        foreach (plan[r])
        begin
            if (plan[r].unit != unit_now || plan[r].par != parity_now)
                apply_setting(plan[r].unit, plan[r].par);
            send_word(plan[r].func, plan[r].bits, plan[r].len, plan[r].typed, plan[r].want);
            if (plan[r].tail == TO_IDLE)
            begin
                while (tx_run)
                    send_tick();
            end
            else
                repeat (plan[r].tail) send_tick();
        end

        // Random phases, two per idle pattern, each with its own setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 2)
            begin
                send_gap_pct = 47;
                recv_gap_pct = 27;
            end
            else if (phase == 4)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            case (phase)
                0:       begin unit = 8'd1; par = 1'b1; end
                1:       begin unit = 8'd2; par = 1'b0; end
                2:       begin unit = 8'd1; par = 1'b0; end
                3:       begin unit = 8'd3; par = 1'b1; end
                4:       begin unit = 8'd1; par = 1'b1; end
                default:
                begin
                    unit = UNIT_W'($urandom_range(1, 6));
                    par  = 1'($urandom_range(1));
                end
            endcase
            apply_setting(unit, par);
            // Stall the receiver while words keep coming.
            hold_request = 1'b1;
            stop_at = live_words + PHASE_WORDS;
            while (live_words < stop_at)
                random_frame_run();
        end

        // Drain, let the pipeline settle with a margin, then report.
        item_ch.valid <= 1'b0;
        while (pin_expected.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
